@@ design/dtcf_pkg.sv @@
`timescale 1ns / 1ps

package dtcf_pkg;

  // binary64 layout
  localparam int DBL_W       = 64;
  localparam int DBL_FRAC_W  = 52;
  localparam int DBL_EXP_W   = 11;
  localparam int DBL_SIGN    = 63;
  localparam logic [DBL_EXP_W-1:0] DBL_EXP_ONES = 11'h7FF;
  localparam logic [63:0] DBL_BIAS = 64'd1023;

  // custom format configuration
  localparam int TW_W        = 7;
  localparam int EW_W        = 6;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 7;
  localparam logic [TW_W-1:0] TW_RESET = 7'd32;
  localparam logic [EW_W-1:0] EW_RESET = 6'd8;
  localparam logic [TW_W-1:0] TW_MIN   = 7'd3;
  localparam logic [TW_W-1:0] TW_MAX   = 7'd64;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TOTAL_WIDTH    = 1'b0,
    REG_EXPONENT_WIDTH = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [TW_W-1:0] total_width;
    logic [EW_W-1:0] exponent_width;
  } fmt_cfg_t;

  // ones in the low n bits, all ones for n of 64 or more
  function automatic logic [DBL_W-1:0] low_mask(input logic [TW_W-1:0] n);
    if (n >= TW_MAX) return '1;
    return (64'd1 << n[5:0]) - 64'd1;
  endfunction

endpackage

@@ design/dtcf_conv.sv @@
`timescale 1ns / 1ps

module dtcf_conv (
  input  logic [63:0]          double_bits,
  input  dtcf_pkg::fmt_cfg_t   cfg,
  output logic [63:0]          custom_bits,
  output logic                 config_error
);
  import dtcf_pkg::*;

  logic [TW_W-1:0]        tw;
  logic [TW_W-1:0]        ew7;
  logic [TW_W-1:0]        fw7;
  logic [5:0]             fw;
  logic [5:0]             tw1;
  logic                   sign;
  logic [DBL_EXP_W-1:0]   dexp;
  logic [DBL_EXP_W-1:0]   dexp_eff;
  logic [DBL_FRAC_W-1:0]  dfrac;
  logic [DBL_FRAC_W:0]    sig;
  logic [63:0]            w0, w1, w2, w3, w4, w5, w6;
  logic [5:0]             lz;
  logic [DBL_FRAC_W-1:0]  frac52;
  logic [63:0]            exp_ones;
  logic [63:0]            bias;
  logic [63:0]            frac_ones;
  logic [63:0]            sign_mask;
  logic [63:0]            head;
  logic signed [63:0]     biased;
  logic signed [63:0]     sub_shift;
  logic [63:0]            sub_neg;
  logic [63:0]            norm_frac;
  logic [63:0]            sub_frac;
  logic [63:0]            result;

  // configuration decode
  assign tw  = cfg.total_width;
  assign ew7 = {1'b0, cfg.exponent_width};
  assign fw7 = tw - ew7 - 7'd1;
  assign fw  = fw7[5:0];
  assign tw1 = 6'(tw - 7'd1);
  assign config_error = (tw < TW_MIN) || (tw > TW_MAX) || (ew7 == 7'd0) ||
                        (ew7 > tw - 7'd2);

  // field split
  assign sign  = double_bits[DBL_SIGN];
  assign dexp  = double_bits[DBL_SIGN-1:DBL_FRAC_W];
  assign dfrac = double_bits[DBL_FRAC_W-1:0];
  assign sig   = {(dexp != '0), dfrac};
  assign dexp_eff = (dexp == '0) ? 11'd1 : dexp;

  // leading zero count and normalising shift, halving steps
  assign w0 = {sig, 11'd0};
  assign lz[5] = (w0[63:32] == '0);
  assign w1    = lz[5] ? (w0 << 32) : w0;
  assign lz[4] = (w1[63:48] == '0);
  assign w2    = lz[4] ? (w1 << 16) : w1;
  assign lz[3] = (w2[63:56] == '0);
  assign w3    = lz[3] ? (w2 << 8) : w2;
  assign lz[2] = (w3[63:60] == '0);
  assign w4    = lz[2] ? (w3 << 4) : w3;
  assign lz[1] = (w4[63:62] == '0);
  assign w5    = lz[1] ? (w4 << 2) : w4;
  assign lz[0] = ~w5[63];
  assign w6    = lz[0] ? (w5 << 1) : w5;
  assign frac52 = w6[62:11];

  // masks and sign position
  assign exp_ones  = low_mask(ew7);
  assign bias      = low_mask(ew7 - 7'd1);
  assign frac_ones = low_mask({1'b0, fw});
  assign sign_mask = low_mask(tw - 7'd1);
  assign head      = {63'd0, sign} << tw1;

  // rebiased exponent of the leading one
  assign biased = $signed({53'd0, dexp_eff}) - $signed(DBL_BIAS)
                - $signed({58'd0, lz}) + $signed(bias);

  // subnormal alignment, a left shift of at most nine for a valid configuration or a right shift
  assign sub_shift = biased + $signed({58'd0, lz}) - 64'sd53 + $signed({58'd0, fw});
  assign sub_neg   = 64'(-sub_shift);

  // fraction of a normal result
  always_comb begin
    if (fw >= 6'd52) norm_frac = {12'd0, frac52} << (fw - 6'd52);
    else             norm_frac = {12'd0, frac52} >> (6'd52 - fw);
  end

  // fraction of a subnormal result
  always_comb begin
    if (!sub_shift[63])        sub_frac = {11'd0, sig} << sub_shift[5:0];
    else if (sub_neg < 64'd64) sub_frac = {11'd0, sig} >> sub_neg[5:0];
    else                       sub_frac = '0;
  end

  // case selection
  always_comb begin
    priority if (dexp == DBL_EXP_ONES) begin
      if (dfrac == '0) result = head | (sign_mask & ~frac_ones);
      else             result = head | sign_mask;
    end else if (sig == '0) begin
      result = head;
    end else if (biased >= $signed(exp_ones)) begin
      result = head | (sign_mask & ~frac_ones);
    end else if (biased > 64'sd0) begin
      result = head | (64'(biased) << fw) | norm_frac;
    end else begin
      result = head | (sub_frac & frac_ones);
    end
  end

  assign custom_bits = config_error ? '0 : (result & low_mask(tw));

endmodule

@@ design/double_to_custom_float_top.sv @@
`timescale 1ns / 1ps
// double to custom float converter
// a request accepted into the input register moves on to the result register
// when the output is free; throughput one request per cycle while the output is not stalled
// the input register and the result register form a two entry pipeline
// reset clears both valid flags and loads total width 32, exponent width 8

module double_to_custom_float_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [63:0]                         double_bits,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [63:0]                         custom_bits,
  output logic                                config_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dtcf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [dtcf_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dtcf_pkg::*;

  fmt_cfg_t     cfg;
  logic         in_full;
  logic [63:0]  in_bits;
  logic         out_adv;
  logic         in_adv;
  logic [63:0]  conv_bits;
  logic         conv_error;

  // handshake
  assign out_adv   = ~out_valid | out_ready;
  assign in_ready  = ~in_full | out_adv;
  assign in_adv    = in_valid & in_ready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.total_width    <= TW_RESET;
      cfg.exponent_width <= EW_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TOTAL_WIDTH:    cfg.total_width    <= cfg_data[TW_W-1:0];
        REG_EXPONENT_WIDTH: cfg.exponent_width <= cfg_data[EW_W-1:0];
        default:            cfg.total_width    <= cfg.total_width;
      endcase
    end
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) in_full <= in_valid;
      if (out_adv)  out_valid <= in_full;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_adv) in_bits <= double_bits;
    if (out_adv && in_full) begin
      custom_bits  <= conv_bits;
      config_error <= conv_error;
    end
  end

  dtcf_conv u_conv (
    .double_bits  (in_bits),
    .cfg          (cfg),
    .custom_bits  (conv_bits),
    .config_error (conv_error)
  );

endmodule

@@ design/dtcf_checker.sv @@
`timescale 1ns / 1ps

module dtcf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] custom_bits,
  input logic        config_error
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(custom_bits) && $stable(config_error))
    else $error("stalled result changed");

  // a bad configuration gives a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && config_error |-> custom_bits == 64'd0)
    else $error("config error with nonzero result");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // an empty output stage never blocks a request
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

endmodule

bind double_to_custom_float_top dtcf_checker u_dtcf_checker (.*);
